// ===== rtl/esa_pkg.sv =====
// esa_pkg: sizes, command and register codes, and shared types for the
// entity slot allocator. No dependencies.
package esa_pkg;

  localparam int SLOTS           = 256;
  localparam int COMPONENT_TYPES = 8;
  localparam int SIZE_BITS       = 16;

  localparam int SLOT_AW  = $clog2(SLOTS);
  localparam int NF_W     = $clog2(SLOTS + 1);
  localparam int MASK_W   = 8;
  localparam int IDX_W    = 8;
  localparam int USED_W   = 27;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 2;
  localparam int ENTRY_W  = MASK_W + 1;
  localparam int PAIRS    = (COMPONENT_TYPES + 1) / 2;
  localparam int SUM_W    = SIZE_BITS + 3;
  localparam int SIZE_STRIDE = 16;

  localparam logic [1:0] CMD_CREATE  = 2'd0;
  localparam logic [1:0] CMD_DESTROY = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_REGISTERED_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZES_LOW       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZES_HIGH      = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SUM1,
    ST_SUM2,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [MASK_W-1:0] registered_mask;
    logic [CFG_W-1:0]  sizes_low;
    logic [CFG_W-1:0]  sizes_high;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        slot;
    logic              status;
    logic [MASK_W-1:0] slot_mask;
    logic              authority;
    logic [USED_W-1:0] bytes_in_use;
  } result_t;

endpackage

// ===== rtl/esa_ram.sv =====
// esa_ram: generic simple dual-port RAM, one write and one read port,
// registered read data held while read enable is low. No dependencies.
module esa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/esa_bytes.sv =====
// esa_bytes: byte total of a component mask over registered components,
// two register stages (pair sums, then total). Depends on esa_pkg.
module esa_bytes (
  input  logic                         clk,
  input  logic [esa_pkg::MASK_W-1:0]   mask_in,
  input  esa_pkg::cfg_t                cfg,
  output logic [esa_pkg::SUM_W-1:0]    total
);
  import esa_pkg::*;

  logic [2*CFG_W-1:0] sizes_all;
  logic [SUM_W-1:0]   term [COMPONENT_TYPES];
  logic [SUM_W-1:0]   pair_next [PAIRS];
  logic [SUM_W-1:0]   pair [PAIRS];
  logic [SUM_W-1:0]   total_next;

  assign sizes_all = {cfg.sizes_high, cfg.sizes_low};

  always_comb begin
    for (int c = 0; c < COMPONENT_TYPES; c++) begin
      if (mask_in[c] && cfg.registered_mask[c]) begin
        term[c] = SUM_W'(sizes_all[c*SIZE_STRIDE +: SIZE_BITS]);
      end else begin
        term[c] = '0;
      end
    end
    for (int p = 0; p < PAIRS; p++) begin
      if (2*p + 1 < COMPONENT_TYPES) begin
        pair_next[p] = term[2*p] + term[2*p+1];
      end else begin
        pair_next[p] = term[2*p];
      end
    end
  end

  always_comb begin
    total_next = '0;
    for (int p = 0; p < PAIRS; p++) begin
      total_next = total_next + pair[p];
    end
  end

  always_ff @(posedge clk) begin
    pair  <= pair_next;
    total <= total_next;
  end

endmodule

// ===== rtl/esa_ctrl.sv =====
// esa_ctrl: command sequencer around the slot RAM: clearing pass, lookup,
// byte accounting, free-slot scan and result hand-off. Depends on esa_pkg.
module esa_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    command,
  input  logic [esa_pkg::IDX_W-1:0]     entity_index,
  input  logic [esa_pkg::MASK_W-1:0]    component_mask,
  input  esa_pkg::cfg_t                 cfg,
  output logic                          res_valid,
  input  logic                          res_take,
  output esa_pkg::result_t              res
);
  import esa_pkg::*;

  state_t state, state_next;

  logic [SLOT_AW-1:0] clr_ptr;
  logic [NF_W-1:0]    nf;
  logic [NF_W-1:0]    probe;
  logic [USED_W-1:0]  used;
  logic [1:0]         cmd_q;
  logic [IDX_W-1:0]   idx_q;
  logic [MASK_W-1:0]  cmask_q;
  logic               sub;
  logic [7:0]         res_slot;
  logic               res_status;
  logic [MASK_W-1:0]  res_mask;
  logic               res_auth;

  logic               we, re;
  logic [SLOT_AW-1:0] waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;
  logic [MASK_W-1:0]  bmask;
  logic [SUM_W-1:0]   total;

  logic accept, in_ok, idx_ok, nf_ok, stop;
  logic [NF_W-1:0] probe_inc;

  assign accept    = in_valid && !in_stall;
  assign in_ok     = 32'(entity_index) < SLOTS;
  assign idx_ok    = 32'(idx_q) < SLOTS;
  assign nf_ok     = nf < NF_W'(SLOTS);
  assign probe_inc = probe + NF_W'(1);
  assign stop      = (probe == NF_W'(SLOTS)) || (rdata[MASK_W-1:0] == '0);

  esa_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  esa_bytes u_bytes (
    .clk     (clk),
    .mask_in (bmask),
    .cfg     (cfg),
    .total   (total)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_ptr == SLOT_AW'(SLOTS - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (accept) state_next = ST_LOOKUP;
      ST_LOOKUP: begin
        case (cmd_q)
          CMD_CREATE:  state_next = nf_ok  ? ST_SUM1 : ST_DONE;
          CMD_DESTROY: state_next = idx_ok ? ST_SUM1 : ST_DONE;
          default:     state_next = ST_DONE;
        endcase
      end
      ST_SUM1:   state_next = ST_SUM2;
      ST_SUM2:   state_next = (cmd_q == CMD_CREATE) ? ST_SCAN : ST_DONE;
      ST_SCAN:   if (stop) state_next = ST_DONE;
      ST_DONE:   if (res_take) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs and RAM port control
  always_comb begin
    in_stall  = 1'b1;
    res_valid = 1'b0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    re        = 1'b0;
    raddr     = '0;
    bmask     = cmask_q;
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_ptr;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        re       = in_valid && in_ok;
        raddr    = SLOT_AW'(entity_index);
      end
      ST_LOOKUP: begin
        if (cmd_q == CMD_CREATE) begin
          we    = nf_ok;
          waddr = SLOT_AW'(nf);
          wdata = {1'b1, cmask_q};
        end else if (cmd_q == CMD_DESTROY) begin
          we    = idx_ok;
          waddr = SLOT_AW'(idx_q);
          bmask = rdata[MASK_W-1:0];
        end
      end
      ST_SUM2: begin
        re    = (cmd_q == CMD_CREATE) && (probe < NF_W'(SLOTS));
        raddr = SLOT_AW'(probe);
      end
      ST_SCAN: begin
        re    = !stop && (probe_inc < NF_W'(SLOTS));
        raddr = SLOT_AW'(probe_inc);
      end
      ST_DONE:  res_valid = 1'b1;
      default:  in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_ptr <= '0;
      nf      <= '0;
      used    <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_ptr <= clr_ptr + SLOT_AW'(1);
      end
      if (state == ST_LOOKUP && cmd_q == CMD_DESTROY && idx_ok && NF_W'(idx_q) < nf) begin
        nf <= NF_W'(idx_q);
      end
      if (state == ST_SUM2) begin
        if (sub) begin
          used <= used - USED_W'(total);
        end else begin
          used <= used + USED_W'(total);
        end
      end
      if (state == ST_SCAN && stop) begin
        nf <= probe;
      end
    end
  end

  // beat payload and per-command working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= command;
      idx_q   <= entity_index;
      cmask_q <= component_mask;
    end
    if (state == ST_LOOKUP) begin
      case (cmd_q)
        CMD_CREATE: begin
          sub <= 1'b0;
          if (nf_ok) begin
            res_slot   <= 8'(nf);
            res_status <= 1'b0;
            res_mask   <= cmask_q;
            res_auth   <= 1'b1;
            probe      <= nf + NF_W'(1);
          end else begin
            res_slot   <= '0;
            res_status <= 1'b1;
            res_mask   <= '0;
            res_auth   <= 1'b0;
          end
        end
        CMD_DESTROY: begin
          res_slot   <= idx_q;
          res_status <= 1'b0;
          res_mask   <= '0;
          res_auth   <= 1'b0;
          sub        <= 1'b1;
        end
        default: begin
          res_slot   <= idx_q;
          res_status <= 1'b0;
          sub        <= 1'b0;
          if (idx_ok) begin
            res_mask <= rdata[MASK_W-1:0];
            res_auth <= rdata[MASK_W];
          end else begin
            res_mask <= '0;
            res_auth <= 1'b0;
          end
        end
      endcase
    end
    if (state == ST_SCAN && !stop) begin
      probe <= probe_inc;
    end
  end

  always_comb begin
    res.slot         = res_slot;
    res.status       = res_status;
    res.slot_mask    = res_mask;
    res.authority    = res_auth;
    res.bytes_in_use = used;
  end

endmodule

// ===== rtl/entity_slot_allocator_top.sv =====
// Entity slot allocator: slot table in one RAM (mask plus authority bit),
// next-free pointer and byte-in-use count. Depends on esa_pkg, esa_ctrl.
// Beat to out_valid: query via lookup and done; destroy via lookup, both
// byte-sum states and done; create also via a free-slot scan (one RAM read a
// cycle), or from lookup to done on a full table. One item at a time; idle,
// where the next beat is taken, is reached as the result enters the output
// register. Reset (rst, synchronous): a clearing pass writes zero to all
// SLOTS RAM entries, one a cycle, with in_stall high; config still taken.
module entity_slot_allocator_top (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_write,
  input  logic [esa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [esa_pkg::CFG_W-1:0]        cfg_data,
  // command channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       command,
  input  logic [esa_pkg::IDX_W-1:0]        entity_index,
  input  logic [esa_pkg::MASK_W-1:0]       component_mask,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       slot,
  output logic                             status,
  output logic [esa_pkg::MASK_W-1:0]       slot_mask,
  output logic                             authority,
  output logic [esa_pkg::USED_W-1:0]       bytes_in_use
);
  import esa_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    res_valid;
  logic    res_take;

  // Configuration registers; writes to an unlisted index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_REGISTERED_MASK: cfg.registered_mask <= cfg_data[MASK_W-1:0];
        CFG_SIZES_LOW:       cfg.sizes_low       <= cfg_data;
        CFG_SIZES_HIGH:      cfg.sizes_high      <= cfg_data;
        default:             cfg                 <= cfg;
      endcase
    end
  end

  esa_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .entity_index   (entity_index),
    .component_mask (component_mask),
    .cfg            (cfg),
    .res_valid      (res_valid),
    .res_take       (res_take),
    .res            (res)
  );

  // Output register: the sequencer hands over a result beat whenever this
  // stage is empty or being drained in the same cycle.
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      slot         <= res.slot;
      status       <= res.status;
      slot_mask    <= res.slot_mask;
      authority    <= res.authority;
      bytes_in_use <= res.bytes_in_use;
    end
  end

endmodule
